// ----- sv/nta_pkg.sv -----
package nta_pkg;

  typedef enum logic [1:0] {
    ModeAddNs   = 2'd0,
    ModeDiff    = 2'd1,
    ModeToStamp = 2'd2,
    ModeToTime  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CfgBaseUnixSec  = 2'd0,
    CfgBaseMicrosec = 2'd1,
    CfgBaseMonoNs   = 2'd2
  } cfg_idx_t;

  localparam logic [29:0] NsPerSec    = 30'd1000000000;
  localparam logic [9:0]  NsPerUs     = 10'd1000;
  localparam logic [32:0] EpochOffset = 33'd2208988800;
  // floor(2^48 / 1e9), quotient estimate for one 16-bit digit
  localparam logic [18:0] RecipNs     = 19'd281474;

  // item state through the divide chain
  typedef struct packed {
    logic [63:0] n;         // dividend digits still to go, msb first
    logic [29:0] rem;       // running remainder
    logic [63:0] quo;       // last four quotient digits
    logic [31:0] sec_base;  // seconds added to the quotient
    logic [63:0] diff;      // result of the difference modes
    logic        use_div;
    logic        err;
  } nta_div_t;

endpackage

// ----- sv/ntp_timestamp_arithmetic_top.sv -----
// throughput: one item per cycle, limited by nothing but out_ready
// 3 front stages (products, sums and checks), 6 divide-by-1e9 digit steps
// of 2 stages each, 1 output register; the whole pipe stalls together
// reset: synchronous active-low rst_n clears valid bits and base registers
module ntp_timestamp_arithmetic_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_stamp_a,
  input  logic [63:0] in_stamp_b,
  input  logic [63:0] in_nanoseconds,
  input  logic [63:0] in_mono_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_value,
  output logic        out_error,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import nta_pkg::*;

  localparam int Steps = 6;

  logic [30:0] base_unix_r;
  logic [19:0] base_us_r;
  logic [63:0] base_mono_r;
  logic        en;
  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic        out_error_r;

  logic        chain_v [Steps+1];
  nta_div_t    chain_d [Steps+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_unix_r <= '0;
      base_us_r   <= '0;
      base_mono_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CfgBaseUnixSec:  base_unix_r <= cfg_wdata[30:0];
        CfgBaseMicrosec: base_us_r   <= cfg_wdata[19:0];
        CfgBaseMonoNs:   base_mono_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  nta_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_valid),
    .in_mode        (in_mode),
    .in_stamp_a     (in_stamp_a),
    .in_stamp_b     (in_stamp_b),
    .in_nanoseconds (in_nanoseconds),
    .in_mono_time   (in_mono_time),
    .base_unix_sec  (base_unix_r),
    .base_us        (base_us_r),
    .base_mono      (base_mono_r),
    .out_valid      (chain_v[0]),
    .out_data       (chain_d[0])
  );

  // long division of {n, 32'b0} by 1e9, 16 bits a step
  for (genvar i = 0; i < Steps; i++) begin : g_step
    nta_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (chain_v[i]),
      .in_data   (chain_d[i]),
      .out_valid (chain_v[i+1]),
      .out_data  (chain_d[i+1])
    );
  end

  nta_div_t    last;
  logic [63:0] value_nxt;

  assign last = chain_d[Steps];

  always_comb begin
    if (last.err) begin
      value_nxt = 64'd0;
    end else if (last.use_div) begin
      value_nxt = {last.sec_base + last.quo[63:32], last.quo[31:0]};
    end else begin
      value_nxt = last.diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain_v[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= value_nxt;
      out_error_r <= last.err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_error        = out_error_r;

endmodule

// ----- sv/nta_div_step.sv -----
module nta_div_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  nta_pkg::nta_div_t in_data,
  output logic             out_valid,
  output nta_pkg::nta_div_t out_data
);
  import nta_pkg::*;

  logic [45:0] x;
  logic [48:0] est_prod;
  logic        valid_a_r;
  logic [45:0] x_a_r;
  logic [15:0] qe_a_r;
  nta_div_t    data_a_r;
  logic [45:0] back_prod;
  logic [45:0] r_raw;
  logic        fix;
  logic [29:0] rem_nxt;
  logic [15:0] q_nxt;
  nta_div_t    out_nxt;
  logic        out_valid_r;
  nta_div_t    out_data_r;

  // estimate is low by at most one
  assign x        = {in_data.rem, in_data.n[63:48]};
  assign est_prod = 49'(x[45:16]) * 49'(RecipNs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (en) begin
      valid_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_a_r    <= x;
      qe_a_r   <= est_prod[47:32];
      data_a_r <= in_data;
    end
  end

  assign back_prod = 46'(qe_a_r) * 46'(NsPerSec);
  assign r_raw     = x_a_r - back_prod;
  assign fix       = r_raw[30:0] >= 31'(NsPerSec);
  assign rem_nxt   = fix ? 30'(r_raw[30:0] - 31'(NsPerSec)) : r_raw[29:0];
  assign q_nxt     = qe_a_r + 16'(fix);

  always_comb begin
    out_nxt     = data_a_r;
    out_nxt.n   = {data_a_r.n[47:0], 16'd0};
    out_nxt.rem = rem_nxt;
    out_nxt.quo = {data_a_r.quo[47:0], q_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/nta_front.sv -----
module nta_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [1:0]       in_mode,
  input  logic [63:0]      in_stamp_a,
  input  logic [63:0]      in_stamp_b,
  input  logic [63:0]      in_nanoseconds,
  input  logic [63:0]      in_mono_time,
  input  logic [30:0]      base_unix_sec,
  input  logic [19:0]      base_us,
  input  logic [63:0]      base_mono,
  output logic             out_valid,
  output nta_pkg::nta_div_t out_data
);
  import nta_pkg::*;

  logic [32:0] s0;
  logic [29:0] us_ns;
  logic [61:0] fa_prod, fb_prod;
  logic [32:0] sec_a, sec_b;
  logic [62:0] sec_a_prod, sec_b_prod;
  mode_t       mode;

  // stage 1
  logic        v1_r;
  mode_t       mode1_r;
  logic [29:0] nfa1_r, nfb1_r, us_ns1_r;
  logic [32:0] seca1_r, secb1_r;
  logic [62:0] seca_e9_1_r, secb_e9_1_r;
  logic        eq1_r, zero1_r, gt1_r;
  logic [63:0] ns1_r, dmt1_r;
  logic [31:0] sa_hi1_r, s0_lo1_r;

  assign mode  = mode_t'(in_mode);
  assign s0    = 33'(base_unix_sec) + EpochOffset;
  assign us_ns = 30'(base_us) * 30'(NsPerUs);
  assign fa_prod = 62'(in_stamp_a[31:0]) * 62'(NsPerSec);
  assign fb_prod = 62'(in_stamp_b[31:0]) * 62'(NsPerSec);

  // minuend side first, subtrahend side second
  always_comb begin
    if (mode == ModeDiff) begin
      sec_a = {1'b0, in_stamp_b[63:32]};
      sec_b = {1'b0, in_stamp_a[63:32]};
    end else begin
      sec_a = {1'b0, in_stamp_a[63:32]};
      sec_b = s0;
    end
  end

  assign sec_a_prod = 63'(sec_a) * 63'(NsPerSec);
  assign sec_b_prod = 63'(sec_b) * 63'(NsPerSec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r     <= mode;
      nfa1_r      <= fa_prod[61:32];
      nfb1_r      <= fb_prod[61:32];
      us_ns1_r    <= us_ns;
      seca1_r     <= sec_a;
      secb1_r     <= sec_b;
      seca_e9_1_r <= sec_a_prod;
      secb_e9_1_r <= sec_b_prod;
      eq1_r       <= in_stamp_a == in_stamp_b;
      zero1_r     <= in_stamp_a == 64'd0;
      gt1_r       <= in_mono_time > base_mono;
      ns1_r       <= in_nanoseconds;
      dmt1_r      <= in_mono_time - base_mono;
      sa_hi1_r    <= in_stamp_a[63:32];
      s0_lo1_r    <= s0[31:0];
    end
  end

  // stage 2
  logic [29:0] n_a, n_b;
  logic        sec_lt, sec_eq;
  logic        err2;
  logic [63:0] n_div;
  logic [31:0] sec_base;
  logic        v2_r;
  logic        m3_2_r, use_div2_r, err2_r;
  logic [63:0] ta2_r, tb2_r, ndiv2_r;
  logic [31:0] secbase2_r;

  assign n_a    = (mode1_r == ModeDiff) ? nfb1_r : nfa1_r;
  assign n_b    = (mode1_r == ModeDiff) ? nfa1_r : us_ns1_r;
  assign sec_lt = seca1_r < secb1_r;
  assign sec_eq = seca1_r == secb1_r;

  always_comb begin
    unique case (mode1_r)
      ModeAddNs: begin
        err2     = 1'b0;
        n_div    = 64'(nfa1_r) + ns1_r;
        sec_base = sa_hi1_r;
      end
      ModeDiff: begin
        err2     = sec_lt || (sec_eq && (n_a < n_b)) || eq1_r;
        n_div    = 64'd0;
        sec_base = 32'd0;
      end
      ModeToStamp: begin
        err2     = !gt1_r;
        n_div    = dmt1_r + 64'(us_ns1_r);
        sec_base = s0_lo1_r;
      end
      ModeToTime: begin
        err2     = zero1_r || sec_lt || (sec_eq && (n_a <= n_b));
        n_div    = 64'd0;
        sec_base = 32'd0;
      end
      default: begin
        err2     = 1'b0;
        n_div    = 64'd0;
        sec_base = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_2_r     <= mode1_r == ModeToTime;
      use_div2_r <= (mode1_r == ModeAddNs) || (mode1_r == ModeToStamp);
      err2_r     <= err2;
      ta2_r      <= 64'(seca_e9_1_r) + 64'(n_a);
      tb2_r      <= 64'(secb_e9_1_r) + 64'(n_b);
      ndiv2_r    <= n_div;
      secbase2_r <= sec_base;
    end
  end

  // stage 3
  logic [63:0] offset;
  nta_div_t    d3_nxt;
  logic        v3_r;
  nta_div_t    d3_r;

  assign offset = m3_2_r ? base_mono + 64'd1 : 64'd0;

  always_comb begin
    d3_nxt.n        = ndiv2_r;
    d3_nxt.rem      = 30'd0;
    d3_nxt.quo      = 64'd0;
    d3_nxt.sec_base = secbase2_r;
    d3_nxt.diff     = ta2_r - tb2_r + offset;
    d3_nxt.use_div  = use_div2_r;
    d3_nxt.err      = err2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r <= d3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = d3_r;

endmodule
